// ----- src/assert_macros.svh -----
// Assertion helpers shared by the RTL; bodies vanish when SYNTH is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// prop must hold at every edge outside reset
`define ASSERT_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
// expr must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)
`endif

`endif

// ----- src/brf_pkg.sv -----
package brf_pkg;

  localparam int STORE_BYTES_DEF = 256;
  localparam int BLOCK_MAX_DEF   = 8;

  localparam int DATA_W = 64;
  localparam int LEN_W  = 4;
  localparam int CFG_W  = 4;
  localparam int STS_W  = 2;

  localparam logic [STS_W-1:0] STS_OK    = 2'd0;
  localparam logic [STS_W-1:0] STS_EMPTY = 2'd1;
  localparam logic [STS_W-1:0] STS_FULL  = 2'd2;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic load;      // latch the request and check it
    logic wr_step;   // write one byte at the tail
    logic rd_step;   // issue one byte read at the head
    logic out_load;  // move the finished result into the output register
  } brf_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic op_pop;    // latched request is a pop
    logic reject;    // latched request failed its empty or full check
    logic last;      // current byte is the last one of the block
    logic out_free;  // output register can take a result this cycle
  } brf_sts_t;

endpackage

// ----- src/brf_ram.sv -----
module brf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- src/brf_datapath.sv -----
`include "assert_macros.svh"

module brf_datapath #(
  parameter int STORE_BYTES = 256,
  parameter int BLOCK_MAX   = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [brf_pkg::CFG_W-1:0]       cfg_wr_data,
  input  logic                            in_operation,
  input  logic [brf_pkg::DATA_W-1:0]      in_push_data,
  input  logic [brf_pkg::LEN_W-1:0]       in_push_length,
  input  brf_pkg::brf_cmd_t               cmd,
  output brf_pkg::brf_sts_t               sts,
  input  logic                            out_stall,
  output logic                            out_valid,
  output logic [brf_pkg::STS_W-1:0]       out_status,
  output logic [brf_pkg::DATA_W-1:0]      out_pop_data
);

  import brf_pkg::*;

  localparam int AW = $clog2(STORE_BYTES);
  localparam int HW = $clog2(STORE_BYTES + 1);
  localparam int CW = $clog2(BLOCK_MAX + 1);
  localparam int BW = (BLOCK_MAX > 1) ? $clog2(BLOCK_MAX) : 1;

  logic [CW-1:0]     blk_r;
  logic [AW-1:0]     head_r;
  logic [AW-1:0]     tail_r;
  logic [HW-1:0]     held_r;
  logic              op_r;
  logic [DATA_W-1:0] data_r;
  logic [LEN_W-1:0]  len_r;
  logic [AW-1:0]     addr_r;
  logic [BW-1:0]     idx_r;
  logic [BW-1:0]     lane_r;
  logic              rd_vld_r;
  logic [DATA_W-1:0] pop_r;
  logic [STS_W-1:0]  status_r;
  logic              out_valid_r;
  logic [STS_W-1:0]  out_status_r;
  logic [DATA_W-1:0] out_pop_r;

  logic [CW-1:0] cfg_blk;
  logic          full;
  logic [AW-1:0] sel_ptr;
  logic [AW:0]   ptr_end;
  logic [AW-1:0] start_ptr;
  logic [AW:0]   addr_inc;
  logic [AW-1:0] addr_nxt;
  logic [HW-1:0] held_pop;
  logic          last;
  logic [7:0]    wr_byte;
  logic [7:0]    rd_byte;

  // clamp the written block size into 1..BLOCK_MAX
  always_comb begin
    if (cfg_wr_data == '0) begin
      cfg_blk = CW'(1);
    end else if (cfg_wr_data > CFG_W'(BLOCK_MAX)) begin
      cfg_blk = CW'(BLOCK_MAX);
    end else begin
      cfg_blk = CW'(cfg_wr_data);
    end
  end

  assign full = ({1'b0, held_r} + (HW+1)'(blk_r)) > (HW+1)'(STORE_BYTES);

  // wrap the start pointer when the block would run past the end
  assign sel_ptr   = (in_operation == OP_POP) ? head_r : tail_r;
  assign ptr_end   = {1'b0, sel_ptr} + (AW+1)'(blk_r);
  assign start_ptr = (ptr_end > (AW+1)'(STORE_BYTES)) ? '0 : sel_ptr;

  assign addr_inc = {1'b0, addr_r} + (AW+1)'(1);
  assign addr_nxt = (addr_inc >= (AW+1)'(STORE_BYTES)) ? '0 : addr_inc[AW-1:0];

  assign held_pop = (held_r >= HW'(blk_r)) ? (held_r - HW'(blk_r)) : '0;
  assign last     = (CW'(idx_r) == (blk_r - CW'(1)));
  assign wr_byte  = (LEN_W'(idx_r) < len_r) ? data_r[7:0] : 8'd0;

  brf_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.wr_step),
    .waddr (addr_r),
    .wdata (wr_byte),
    .raddr (addr_r),
    .rdata (rd_byte)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_r       <= CW'(1);
      head_r      <= '0;
      tail_r      <= '0;
      held_r      <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        op_r   <= in_operation;
        data_r <= in_push_data;
        len_r  <= in_push_length;
        idx_r  <= '0;
        addr_r <= start_ptr;
        pop_r  <= '0;
        if (in_operation == OP_POP) begin
          status_r <= (held_r == '0) ? STS_EMPTY : STS_OK;
        end else begin
          status_r <= full ? STS_FULL : STS_OK;
        end
      end

      if (cmd.wr_step) begin
        data_r <= data_r >> 8;
        idx_r  <= idx_r + 1'b1;
        addr_r <= addr_nxt;
        if (last) begin
          tail_r <= addr_nxt;
          held_r <= held_r + HW'(blk_r);
        end
      end

      if (cmd.rd_step) begin
        idx_r  <= idx_r + 1'b1;
        addr_r <= addr_nxt;
        if (last) begin
          head_r <= addr_nxt;
          held_r <= held_pop;
        end
      end

      // read data lands in the cycle after the address
      rd_vld_r <= cmd.rd_step;
      lane_r   <= idx_r;
      if (rd_vld_r) begin
        for (int k = 0; k < BLOCK_MAX; k++) begin
          if (lane_r == BW'(k)) begin
            pop_r[8*k +: 8] <= rd_byte;
          end
        end
      end

      if (cmd.out_load) begin
        out_valid_r  <= 1'b1;
        out_status_r <= status_r;
        out_pop_r    <= pop_r;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      // a size write empties the queue
      if (cfg_wr_en) begin
        blk_r  <= cfg_blk;
        head_r <= '0;
        tail_r <= '0;
        held_r <= '0;
      end
    end
  end

  assign sts.op_pop   = (op_r == OP_POP);
  assign sts.reject   = (status_r != STS_OK);
  assign sts.last     = last;
  assign sts.out_free = !out_valid_r || !out_stall;

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_pop_data = out_pop_r;

  `ASSERT_PROP(a_held_bound, clk, rst_n, held_r <= HW'(STORE_BYTES))
  `ASSERT_PROP(a_blk_range, clk, rst_n, (blk_r != '0) && (blk_r <= CW'(BLOCK_MAX)))
  `ASSERT_PROP(a_out_load, clk, rst_n, cmd.out_load |=> out_valid_r)

endmodule

// ----- src/brf_ctrl.sv -----
`include "assert_macros.svh"

module brf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  brf_pkg::brf_sts_t sts,
  output brf_pkg::brf_cmd_t cmd
);

  import brf_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_PUSH,
    ST_POP,
    ST_POP_WAIT,
    ST_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   in_stall_r;
  logic   in_stall_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (sts.reject) begin
          state_nxt = ST_DONE;
        end else if (sts.op_pop) begin
          state_nxt = ST_POP;
        end else begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (sts.last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_POP: begin
        if (sts.last) begin
          state_nxt = ST_POP_WAIT;
        end
      end
      ST_POP_WAIT: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    in_stall_nxt = (state_nxt != ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      in_stall_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_stall_r <= in_stall_nxt;
    end
  end

  assign cmd.load     = (state_r == ST_IDLE) && in_valid;
  assign cmd.wr_step  = (state_r == ST_PUSH);
  assign cmd.rd_step  = (state_r == ST_POP);
  assign cmd.out_load = (state_r == ST_DONE) && sts.out_free;
  assign in_stall     = in_stall_r;

  `ASSERT_NEVER(a_step_excl, clk, rst_n, cmd.wr_step && cmd.rd_step)
  `ASSERT_PROP(a_load_stalls, clk, rst_n, cmd.load |=> in_stall_r)
  `ASSERT_PROP(a_idle_open, clk, rst_n, (state_r == ST_IDLE) |-> !in_stall_r)

endmodule

// ----- src/block_ring_fifo.sv -----
// Ring FIFO of fixed-size blocks kept in a byte-wide single-port-write RAM.
// A request is taken in idle and checked; a push then writes and a pop reads the
// block byte by byte over the RAM, and a rejected (full or empty) request skips
// that loop. One request is handled at a time, with in_stall high until it is done;
// a waiting result holds in the output register while the next is taken.
// Reset (rst_n, synchronous, low): queue empty, block size 1; RAM not cleared.
module block_ring_fifo #(
  parameter int STORE_BYTES = brf_pkg::STORE_BYTES_DEF,
  parameter int BLOCK_MAX   = brf_pkg::BLOCK_MAX_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // block size register; a write also empties the queue
  input  logic                       cfg_wr_en,
  input  logic [brf_pkg::CFG_W-1:0]  cfg_wr_data,
  // request channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_operation,
  input  logic [brf_pkg::DATA_W-1:0] in_push_data,
  input  logic [brf_pkg::LEN_W-1:0]  in_push_length,
  // result channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [brf_pkg::STS_W-1:0]  out_status,
  output logic [brf_pkg::DATA_W-1:0] out_pop_data
);

  import brf_pkg::*;

  brf_cmd_t cmd;
  brf_sts_t sts;

  // Sequencer: accept, check, step through the block bytes, hand off result.
  brf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Pointers, occupancy count, byte RAM, pop assembly and output register.
  // The start pointer wraps to zero when a whole block would not fit before
  // the end of memory; the byte after the last one wraps the same way.
  brf_datapath #(
    .STORE_BYTES (STORE_BYTES),
    .BLOCK_MAX   (BLOCK_MAX)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_operation   (in_operation),
    .in_push_data   (in_push_data),
    .in_push_length (in_push_length),
    .cmd            (cmd),
    .sts            (sts),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_pop_data   (out_pop_data)
  );

endmodule
